// ----- src/vnc_pkg.sv -----
// Shared constants for the vector normalize / cross product pipeline.
// No dependencies.
package vnc_pkg;
	localparam int TOP_BIT       = 29;
	localparam int NORM_W        = TOP_BIT + 1;
	localparam int SQ_W          = 2 * NORM_W + 2;
	localparam int ROOT_W        = SQ_W / 2;
	localparam int OUT_FRAC_BITS = 15;
	localparam int OUT_W         = OUT_FRAC_BITS + 2;
endpackage

// ----- src/vnc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with side payload.
// Depends on nothing; widths come from parameters.
module vnc_sqrt #(
	parameter int RAD_W  = 62,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [RAD_W/2-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = RAD_W / 2;

	logic [RW:0]       rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [RAD_W-1:0]  rad_s  [RW];
	logic [SIDE_W-1:0] side_s [RW];
	logic              vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW:0]       rem_p;
		logic [RW-1:0]     root_p;
		logic [RAD_W-1:0]  rad_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [RW+2:0]     cat, trial, dif;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign side_p = side_in;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign cat   = {rem_p, rad_p[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign dif   = cat - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[RAD_W-3:0], 2'b00};
				side_s[k] <= side_p;
				if (cat >= trial) begin
					rem_s[k]  <= dif[RW:0];
					root_s[k] <= {root_p[RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cat[RW:0];
					root_s[k] <= {root_p[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];
endmodule

// ----- src/vnc_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage, with side payload. Depends on nothing.
module vnc_div #(
	parameter int NUM_W  = 46,
	parameter int DEN_W  = 31,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [2:0][NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]          den,
	input  logic [SIDE_W-1:0]         side_in,
	output logic                      out_vld,
	output logic [2:0][Q_W-1:0]       quo,
	output logic [SIDE_W-1:0]         side_out
);
	localparam int HI_W = NUM_W - Q_W;

	logic [2:0][DEN_W-1:0] rem_s  [Q_W];
	logic [2:0][Q_W-1:0]   low_s  [Q_W];
	logic [2:0][Q_W-1:0]   quo_s  [Q_W];
	logic [DEN_W-1:0]      den_s  [Q_W];
	logic [SIDE_W-1:0]     side_s [Q_W];
	logic                  vld_s  [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [2:0][DEN_W-1:0] rem_p;
		logic [2:0][Q_W-1:0]   low_p;
		logic [2:0][Q_W-1:0]   quo_p;
		logic [DEN_W-1:0]      den_p;
		logic [SIDE_W-1:0]     side_p;
		logic                  vld_p;

		if (j == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_p[l] = {{(DEN_W-HI_W){1'b0}}, num[l][NUM_W-1:Q_W]};
				assign low_p[l] = num[l][Q_W-1:0];
			end
			assign quo_p  = '0;
			assign den_p  = den;
			assign side_p = side_in;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign low_p  = low_s[j-1];
			assign quo_p  = quo_s[j-1];
			assign den_p  = den_s[j-1];
			assign side_p = side_s[j-1];
			assign vld_p  = vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			logic [DEN_W:0] cat;
			if (en) begin
				den_s[j]  <= den_p;
				side_s[j] <= side_p;
				for (int l = 0; l < 3; l++) begin
					cat = {rem_p[l], low_p[l][Q_W-1]};
					low_s[j][l] <= {low_p[l][Q_W-2:0], 1'b0};
					if (cat >= {1'b0, den_p}) begin
						rem_s[j][l] <= DEN_W'(cat - {1'b0, den_p});
						quo_s[j][l] <= {quo_p[l][Q_W-2:0], 1'b1};
					end else begin
						rem_s[j][l] <= cat[DEN_W-1:0];
						quo_s[j][l] <= {quo_p[l][Q_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign quo      = quo_s[Q_W-1];
	assign side_out = side_s[Q_W-1];
endmodule

// ----- src/vector_normalize_cross.sv -----
// Top level of the vector normalize / cross product pipeline.
// Depends on vnc_pkg, vnc_sqrt and vnc_div.
//
// Takes one beat per cycle unless the output stalls, and returns one beat per
// input beat, in order. The pipeline is seven front stages (products,
// differences, max, leading one, prescale, squares, sum), the 31-stage
// bit-per-stage square root, one numerator stage, one divider stage per
// quotient bit and the output register. A stalled output holds the whole
// pipeline; no beat is lost or repeated. A zero vector gives (0,0,1) with
// was_zero set; in cross mode a zero operand is replaced by (0,0,1) first.
module vector_normalize_cross
	import vnc_pkg::*;
#(
	parameter int COMP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic signed [COMP_BITS-1:0] ax,
	input  logic signed [COMP_BITS-1:0] ay,
	input  logic signed [COMP_BITS-1:0] az,
	input  logic signed [COMP_BITS-1:0] bx,
	input  logic signed [COMP_BITS-1:0] by,
	input  logic signed [COMP_BITS-1:0] bz,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_W-1:0]     nx,
	output logic signed [OUT_W-1:0]     ny,
	output logic signed [OUT_W-1:0]     nz,
	output logic                        was_zero
);
	localparam int CB    = COMP_BITS;
	localparam int MAG_W = 2 * CB;
	localparam int PW    = $clog2(MAG_W);
	localparam int Q_W   = OUT_FRAC_BITS + 1;
	localparam int NUM_W = NORM_W + OUT_FRAC_BITS + 1;
	localparam int SH_W  = MAG_W + TOP_BIT;
	localparam int EW    = Q_W + OUT_W;
	localparam int SIDE1 = 3 * NORM_W + 4;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: products
	logic                         v_s1, act_s1;
	logic signed [2:0][CB-1:0]    a_s1;
	logic signed [5:0][MAG_W-1:0] pr_s1;
	logic signed [CB-1:0]         az_c, bz_c;

	always_comb begin
		az_c = az;
		bz_c = bz;
		if (ax == '0 && ay == '0 && az == '0) az_c = CB'(1);
		if (bx == '0 && by == '0 && bz == '0) bz_c = CB'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= action;
			a_s1     <= {az, ay, ax};
			pr_s1[0] <= ay * bz_c;
			pr_s1[1] <= az_c * by;
			pr_s1[2] <= az_c * bx;
			pr_s1[3] <= ax * bz_c;
			pr_s1[4] <= ax * by;
			pr_s1[5] <= ay * bx;
		end
	end

	// stage 2: sign and magnitude
	logic                  v_s2;
	logic [2:0]            neg_s2;
	logic [2:0][MAG_W-1:0] mag_s2;

	always_ff @(posedge clk) begin
		logic signed [MAG_W:0] d;
		logic signed [CB:0]    s;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (act_s1) begin
					d = {pr_s1[2*i][MAG_W-1], pr_s1[2*i]}
						- {pr_s1[2*i+1][MAG_W-1], pr_s1[2*i+1]};
				end else begin
					s = {a_s1[i][CB-1], a_s1[i]};
					d = (MAG_W+1)'(s);
				end
				neg_s2[i] <= d[MAG_W];
				mag_s2[i] <= d[MAG_W] ? MAG_W'(-d) : d[MAG_W-1:0];
			end
		end
	end

	// stage 3: largest magnitude
	logic                  v_s3, zero_s3;
	logic [2:0]            neg_s3;
	logic [2:0][MAG_W-1:0] mag_s3;
	logic [MAG_W-1:0]      max_s3;

	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] m;
		if (en) begin
			m = mag_s2[0];
			if (mag_s2[1] > m) m = mag_s2[1];
			if (mag_s2[2] > m) m = mag_s2[2];
			max_s3  <= m;
			zero_s3 <= (m == '0);
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
		end
	end

	// stage 4: leading one
	logic                  v_s4, zero_s4;
	logic [2:0]            neg_s4;
	logic [2:0][MAG_W-1:0] mag_s4;
	logic [PW-1:0]         lead_s4;

	always_ff @(posedge clk) begin
		logic [PW-1:0] p;
		if (en) begin
			p = '0;
			for (int b = 0; b < MAG_W; b++) begin
				if (max_s3[b]) p = PW'(b);
			end
			lead_s4 <= p;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			mag_s4  <= mag_s3;
		end
	end

	// stage 5: prescale so the largest magnitude has its top bit at TOP_BIT
	logic                   v_s5, zero_s5;
	logic [2:0]             neg_s5;
	logic [2:0][NORM_W-1:0] nm_s5;

	always_ff @(posedge clk) begin
		logic [SH_W-1:0] w;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w = {mag_s4[i], {TOP_BIT{1'b0}}} >> lead_s4;
				nm_s5[i] <= w[NORM_W-1:0];
			end
			zero_s5 <= zero_s4;
			neg_s5  <= neg_s4;
		end
	end

	// stage 6: squares
	logic                     v_s6, zero_s6;
	logic [2:0]               neg_s6;
	logic [2:0][NORM_W-1:0]   nm_s6;
	logic [2:0][2*NORM_W-1:0] sq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= nm_s5[i] * nm_s5[i];
			end
			nm_s6   <= nm_s5;
			zero_s6 <= zero_s5;
			neg_s6  <= neg_s5;
		end
	end

	// stage 7: sum of squares
	logic                   v_s7, zero_s7;
	logic [2:0]             neg_s7;
	logic [2:0][NORM_W-1:0] nm_s7;
	logic [SQ_W-1:0]        sum_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SQ_W'(sq_s6[0]) + SQ_W'(sq_s6[1]) + SQ_W'(sq_s6[2]);
			nm_s7   <= nm_s6;
			zero_s7 <= zero_s6;
			neg_s7  <= neg_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// length
	logic              sq_vld;
	logic [ROOT_W-1:0] len;
	logic [SIDE1-1:0]  sq_side;

	vnc_sqrt #(
		.RAD_W  (SQ_W),
		.SIDE_W (SIDE1)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s7),
		.rad      (sum_s7),
		.side_in  ({zero_s7, neg_s7, nm_s7}),
		.out_vld  (sq_vld),
		.root     (len),
		.side_out (sq_side)
	);

	// numerators with rounding bias
	logic                   v_s8, zero_s8;
	logic [2:0]             neg_s8;
	logic [2:0][NUM_W-1:0]  num_s8;
	logic [ROOT_W-1:0]      len_s8;
	logic [2:0][NORM_W-1:0] sq_nm;

	assign sq_nm = sq_side[3*NORM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= NUM_W'({sq_nm[i], {OUT_FRAC_BITS{1'b0}}})
					+ NUM_W'(len >> 1);
			end
			len_s8  <= len;
			neg_s8  <= sq_side[3*NORM_W +: 3];
			zero_s8 <= sq_side[SIDE1-1];
		end
	end

	logic                dv_vld;
	logic [2:0][Q_W-1:0] quo;
	logic [3:0]          dv_side;

	vnc_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (ROOT_W),
		.Q_W    (Q_W),
		.SIDE_W (4)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s8),
		.num      (num_s8),
		.den      (len_s8),
		.side_in  ({zero_s8, neg_s8}),
		.out_vld  (dv_vld),
		.quo      (quo),
		.side_out (dv_side)
	);

	// output register: reapply sign, substitute up vector for zero length
	logic [2:0][OUT_W-1:0] res;
	logic [EW-1:0]         one_w;

	assign one_w = EW'(1) << OUT_FRAC_BITS;

	always_comb begin
		logic [EW-1:0] e;
		for (int i = 0; i < 3; i++) begin
			e = EW'(quo[i]);
			if (dv_side[i]) e = -e;
			res[i] = e[OUT_W-1:0];
		end
		if (dv_side[3]) begin
			res[0] = '0;
			res[1] = '0;
			res[2] = one_w[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx       <= res[0];
			ny       <= res[1];
			nz       <= res[2];
			was_zero <= dv_side[3];
		end
	end
endmodule
